// File: hdl/sync_frame_parser_crc16_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync frame parser
// Concurrent checks clocked by clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAME_PARSER_CRC16_MACROS_SVH
`define SYNC_FRAME_PARSER_CRC16_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfp: same-cycle check failed");
// next-cycle implication
`define SFP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfp: next-cycle check failed");
`else
`define SFP_ASSERT_IMPL(name, ante, cons)
`define SFP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: hdl/sfp_pkg.sv
// ---------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the sync frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfp_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 32;
  localparam int TDATA_W  = 96;
  localparam int TUSER_W  = 3;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_LEN = 2'd1,
    STAT_CRC = 2'd2
  } status_t;

  // sequencer states; the first seven take a byte from the link
  typedef enum logic [3:0] {
    S_SYNC_A,
    S_SYNC_B,
    S_TYPE,
    S_LENGTH,
    S_PAYLOAD,
    S_CRC_LO,
    S_CRC_HI,
    S_SHIFT,
    S_REPORT,
    S_FETCH,
    S_EMIT
  } seq_t;

endpackage

// File: hdl/sfp_ram.sv
// ---------------------------------------------------------------------------
// sfp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfp_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/sync_frame_parser_crc16.sv
// Sync-header frame parser with CRC16-CCITT check.
// Input stream (s_*): one received link byte per transaction in s_tdata[7:0].
// Output stream (m_*): one transaction per payload byte of a good frame, or a
// single transaction for an empty good frame, a too-long length or a CRC
// mismatch. m_tlast marks the final transaction of each run.
// Sync and CRC bytes need no CRC step. Type, length and payload bytes are each
// followed by S_SHIFT, where the CRC is folded in one bit per cycle by a single
// shift/xor unit while s_tready stays low; a too-long length skips S_SHIFT.
// A good frame with N payload bytes drains after its last CRC byte, each byte
// via a RAM read (S_FETCH) then an output load (S_EMIT); status results load
// from S_REPORT. The next byte is accepted only after the run has been issued.
// Output register: a finished transaction waits in it while m_tready is low;
// the parser stops at the next result until the slot frees.
// Reset (rst, synchronous): hunting for the sync pair, counters zero, output
// empty. The payload RAM is not cleared; only entries written in the
// current frame are ever read.
// ---------------------------------------------------------------------------
// sync_frame_parser_crc16
// Top level: byte sequencer, bit-serial CRC unit, payload store, result reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_frame_parser_crc16_macros.svh"

module sync_frame_parser_crc16 #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sfp_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [7:0] frame_type, [15:8] frame_length, [21:16] byte_position,
  // [29:22] payload_byte, [61:30] good_frames, [93:62] bad_frames, [95:94] 0
  output logic [sfp_pkg::TDATA_W-1:0] m_tdata,
  output logic [sfp_pkg::TUSER_W-1:0] m_tuser,  // [1:0] status, [2] has_payload
  output logic                       m_tlast    // last
);

  import sfp_pkg::*;

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // sequencer
  seq_t state, state_next;
  seq_t resume;                 // where to return after the CRC shift
  logic [2:0] bit_cnt;

  // frame context
  logic [6:0]        byte_count;
  logic [15:0]       crc;
  logic [7:0]        received_crc_low;
  logic [7:0]        held_type;
  logic [7:0]        held_length;
  status_t           report_status;
  logic [POS_W-1:0]  idx;
  logic [COUNT_W-1:0] good_frame_count;
  logic [COUNT_W-1:0] bad_frame_count;

  // result register
  status_t           out_status;
  logic [7:0]        out_type;
  logic [7:0]        out_len;
  logic [POS_W-1:0]  out_pos;
  logic [7:0]        out_data;
  logic              out_has;
  logic              out_last;
  logic [COUNT_W-1:0] out_good;
  logic [COUNT_W-1:0] out_bad;

  // control
  logic       accept;
  logic       slot_free;
  logic       out_load;
  logic       ram_we;
  logic       len_bad;
  logic       crc_ok;
  logic       emit_last;
  logic [6:0] count_inc;
  logic [7:0] ram_rd_data;
  logic       pos_in_frame;
  logic       count_below_len;

  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign len_bad   = s_tdata > 8'(MAX_PAYLOAD);
  assign crc_ok    = {s_tdata, received_crc_low} == crc;
  assign emit_last = ({2'b00, idx} + 8'd1) == held_length;
  assign count_inc = byte_count + 7'd1;

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_SYNC_A: begin
        if (accept && s_tdata == SYNC_FIRST) begin
          state_next = S_SYNC_B;
        end
      end
      S_SYNC_B: begin
        if (accept) begin
          if (s_tdata == SYNC_SECOND) begin
            state_next = S_TYPE;
          end else if (s_tdata != SYNC_FIRST) begin
            state_next = S_SYNC_A;
          end
        end
      end
      S_TYPE: begin
        if (accept) begin
          state_next = S_SHIFT;
        end
      end
      S_LENGTH: begin
        if (accept) begin
          state_next = len_bad ? S_REPORT : S_SHIFT;
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          state_next = S_SHIFT;
        end
      end
      S_CRC_LO: begin
        if (accept) begin
          state_next = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (accept) begin
          state_next = (crc_ok && held_length != 8'd0) ? S_FETCH : S_REPORT;
        end
      end
      S_SHIFT: begin
        if (bit_cnt == 3'd7) begin
          state_next = resume;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          state_next = S_SYNC_A;
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = emit_last ? S_SYNC_A : S_FETCH;
        end
      end
      default: begin
        state_next = S_SYNC_A;
      end
    endcase
  end

  // output decode
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    ram_we   = 1'b0;
    case (state)
      S_SYNC_A, S_SYNC_B, S_TYPE, S_LENGTH, S_CRC_LO, S_CRC_HI: begin
        s_tready = 1'b1;
      end
      S_PAYLOAD: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid;
      end
      S_REPORT, S_EMIT: begin
        out_load = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // sequencer and frame context
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_SYNC_A;
      resume           <= S_SYNC_A;
      bit_cnt          <= 3'd0;
      byte_count       <= 7'd0;
      crc              <= CRC_INIT;
      received_crc_low <= 8'd0;
      held_type        <= 8'd0;
      held_length      <= 8'd0;
      report_status    <= STAT_OK;
      idx              <= '0;
      good_frame_count <= '0;
      bad_frame_count  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_TYPE: begin
          if (accept) begin
            held_type <= s_tdata;
            crc       <= CRC_INIT ^ {s_tdata, 8'h00};
            resume    <= S_LENGTH;
            bit_cnt   <= 3'd0;
          end
        end
        S_LENGTH: begin
          if (accept) begin
            held_length <= s_tdata;
            byte_count  <= 7'd0;
            bit_cnt     <= 3'd0;
            if (len_bad) begin
              bad_frame_count  <= bad_frame_count + 32'd1;
              report_status    <= STAT_LEN;
              crc              <= CRC_INIT;
              received_crc_low <= 8'd0;
            end else begin
              crc    <= crc ^ {s_tdata, 8'h00};
              resume <= (s_tdata == 8'd0) ? S_CRC_LO : S_PAYLOAD;
            end
          end
        end
        S_PAYLOAD: begin
          if (accept) begin
            byte_count <= count_inc;
            crc        <= crc ^ {s_tdata, 8'h00};
            resume     <= ({1'b0, count_inc} >= held_length) ? S_CRC_LO : S_PAYLOAD;
            bit_cnt    <= 3'd0;
          end
        end
        S_CRC_LO: begin
          if (accept) begin
            received_crc_low <= s_tdata;
          end
        end
        S_CRC_HI: begin
          if (accept) begin
            idx        <= '0;
            byte_count <= 7'd0;
            if (crc_ok) begin
              good_frame_count <= good_frame_count + 32'd1;
              report_status    <= STAT_OK;
            end else begin
              bad_frame_count <= bad_frame_count + 32'd1;
              report_status   <= STAT_CRC;
            end
          end
        end
        S_SHIFT: begin
          // one bit of the MSB-first CRC division per cycle
          crc     <= crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
        end
        S_EMIT: begin
          if (out_load) begin
            idx <= idx + POS_W'(1);
          end
        end
        default: begin
          bit_cnt <= bit_cnt;
        end
      endcase
    end
  end

  // payload store
  sfp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(byte_count[ADDR_W-1:0]),
    .wr_data(s_tdata),
    .rd_addr(idx[ADDR_W-1:0]),
    .rd_data(ram_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // counters are captured with the transaction so later frames cannot
  // change a result that is still waiting
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_type <= held_type;
      out_len  <= held_length;
      out_good <= good_frame_count;
      out_bad  <= bad_frame_count;
      if (state == S_EMIT) begin
        out_status <= STAT_OK;
        out_pos    <= idx;
        out_data   <= ram_rd_data;
        out_has    <= 1'b1;
        out_last   <= emit_last;
      end else begin
        out_status <= report_status;
        out_pos    <= '0;
        out_data   <= 8'd0;
        out_has    <= 1'b0;
        out_last   <= 1'b1;
      end
    end
  end

  assign m_tdata = {2'b00, out_bad, out_good, out_data, out_pos, out_len, out_type};
  assign m_tuser = {out_has, out_status};
  assign m_tlast = out_last;

  // checks
  assign pos_in_frame    = {2'b00, out_pos} < out_len;
  assign count_below_len = {1'b0, byte_count} < held_length;

  `SFP_ASSERT_NEXT(a_shift_returns, state == S_SHIFT && bit_cnt == 3'd7, state == $past(resume))
  `SFP_ASSERT_IMPL(a_payload_pos, m_tvalid && out_has, pos_in_frame)
  `SFP_ASSERT_IMPL(a_status_single, m_tvalid && out_status != STAT_OK, out_last && !out_has)
  `SFP_ASSERT_IMPL(a_count_bound, state == S_PAYLOAD, count_below_len)

endmodule

// File: tb/sync_frame_parser_crc16_tb.sv
// ---------------------------------------------------------------------------
// sync_frame_parser_crc16_tb
// Streams link bytes into the frame parser: directed corner frames first,
// then random frames with random gaps on both sides. A scoreboard predicts
// every result transaction and checks each one against the output stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_frame_parser_crc16_tb;

  import sfp_pkg::*;

  // one output transaction, unpacked into its fields
  typedef struct packed {
    status_t     status;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic [5:0]  pos;
    logic [7:0]  pbyte;
    logic        has_data;
    logic        last;
    logic [31:0] good;
    logic [31:0] bad;
  } frame_result_t;

  class frame_scoreboard;
    localparam int MAX_LEN = 64;

    // parser state as seen from the link side
    seq_t        phase;
    logic [6:0]  pay_count;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic [7:0]  store [MAX_LEN];
    logic [31:0] good;
    logic [31:0] bad;

    frame_result_t pending [$];

    int errors;
    int mismatches;
    int checked;
    int bytes_seen;
    int n_good;
    int n_len;
    int n_crc;

    function new();
      rehunt();
      ftype = '0;
      flen  = '0;
      good  = '0;
      bad   = '0;
    endfunction

    // CRC16-CCITT, MSB first, one byte
    static function logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] b);
      logic [15:0] a;
      a = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
        a = a[15] ? ((a << 1) ^ CRC_POLY) : (a << 1);
      return a;
    endfunction

    function void rehunt();
      phase     = S_SYNC_A;
      pay_count = '0;
      crc       = CRC_INIT;
      crc_lo    = '0;
    endfunction

    function void queue_result(status_t st, logic [5:0] pos, logic [7:0] pb,
                               logic has_data, logic last);
      frame_result_t r;
      r.status   = st;
      r.ftype    = ftype;
      r.flen     = flen;
      r.pos      = pos;
      r.pbyte    = pb;
      r.has_data = has_data;
      r.last     = last;
      r.good     = good;
      r.bad      = bad;
      pending.push_back(r);
    endfunction

    // accepted link byte: advance the parser, queue what it produces
    function void note_byte(logic [7:0] b);
      bytes_seen++;
      case (phase)
        S_SYNC_A: begin
          if (b == SYNC_FIRST) phase = S_SYNC_B;
        end
        S_SYNC_B: begin
          if (b == SYNC_SECOND) phase = S_TYPE;
          else if (b != SYNC_FIRST) phase = S_SYNC_A;
        end
        S_TYPE: begin
          ftype = b;
          crc   = crc_fold(CRC_INIT, b);
          phase = S_LENGTH;
        end
        S_LENGTH: begin
          flen      = b;
          crc       = crc_fold(crc, b);
          pay_count = '0;
          if (int'(b) > MAX_LEN) begin
            bad++;
            n_len++;
            rehunt();
            queue_result(STAT_LEN, '0, '0, 1'b0, 1'b1);
          end else begin
            phase = (b == 8'd0) ? S_CRC_LO : S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          store[pay_count[5:0]] = b;
          pay_count = pay_count + 7'd1;
          crc = crc_fold(crc, b);
          if (pay_count >= {1'b0, flen[6:0]} || flen[7]) phase = S_CRC_LO;
        end
        S_CRC_LO: begin
          crc_lo = b;
          phase  = S_CRC_HI;
        end
        S_CRC_HI: begin
          if ({b, crc_lo} == crc) begin
            good++;
            n_good++;
            if (flen == 8'd0)
              queue_result(STAT_OK, '0, '0, 1'b0, 1'b1);
            else
              for (int i = 0; i < int'(flen) && i < MAX_LEN; i++)
                queue_result(STAT_OK, 6'(i), store[i], 1'b1, (i + 1 == int'(flen)));
          end else begin
            bad++;
            n_crc++;
            queue_result(STAT_CRC, '0, '0, 1'b0, 1'b1);
          end
          rehunt();
        end
        default: rehunt();
      endcase
    endfunction

    function string show(frame_result_t r);
      return $sformatf({"st=%0d type=%02h len=%02h pos=%0d byte=%02h has=%0b last=%0b",
                        " good=%0d bad=%0d"},
                       r.status, r.ftype, r.flen, r.pos, r.pbyte, r.has_data, r.last,
                       r.good, r.bad);
    endfunction

    // output transaction: compare with the oldest prediction
    function void check_result(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser,
                               logic tlast);
      frame_result_t got;
      frame_result_t want;
      got.status   = status_t'(tuser[1:0]);
      got.has_data = tuser[2];
      got.ftype    = tdata[7:0];
      got.flen     = tdata[15:8];
      got.pos      = tdata[21:16];
      got.pbyte    = tdata[29:22];
      got.good     = tdata[61:30];
      got.bad      = tdata[93:62];
      got.last     = tlast;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result: %s", show(got));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.ftype !== want.ftype ||
          got.flen !== want.flen || got.pos !== want.pos ||
          got.pbyte !== want.pbyte || got.has_data !== want.has_data ||
          got.last !== want.last || got.good !== want.good || got.bad !== want.bad) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  localparam int MAX_PAYLOAD  = 64;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int KEEP_ALL     = 1000;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [BYTE_W-1:0]   s_tdata  = '0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [TDATA_W-1:0]  m_tdata;
  logic [TUSER_W-1:0]  m_tuser;
  logic                m_tlast;

  frame_scoreboard sb = new();

  int items_sent  = 0;
  int cycle_count = 0;
  bit tx_calm     = 1'b0;
  bit hold_req    = 1'b0;

  // receiver side
  int rx_hold     = 0;
  int rx_stall    = 0;
  int rx_mode_cnt = 0;
  bit rx_calm     = 1'b0;

  sync_frame_parser_crc16 #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // output sink: checks transactions, stalls at random, honors a long hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold  = HOLD_CYCLES;
      end
      rx_mode_cnt++;
      if (rx_mode_cnt >= 150) begin
        rx_mode_cnt = 0;
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        rx_stall = rx_calm ? 0 : pick_gap();
        m_tready <= (rx_stall == 0);
        if (rx_stall > 0) rx_stall--;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one link byte per transaction
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    if (counted) items_sent++;
  endtask

  // sync pair, header, random payload, CRC (header only when oversized); optionally corrupted or cut short
  task automatic send_frame(input logic [7:0] ftype, input int len, input bit corrupt,
                            input int keep);
    logic [7:0]  link [$];
    logic [7:0]  pb;
    logic [15:0] crc;
    crc = sb.crc_fold(CRC_INIT, ftype);
    crc = sb.crc_fold(crc, 8'(len));
    link.push_back(SYNC_FIRST);
    link.push_back(SYNC_SECOND);
    link.push_back(ftype);
    link.push_back(8'(len));
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        pb = 8'($urandom);
        link.push_back(pb);
        crc = sb.crc_fold(crc, pb);
      end
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      link.push_back(crc[7:0]);
      link.push_back(crc[15:8]);
    end
    for (int i = 0; i < link.size() && i < keep; i++) send_byte(link[i], 1'b1);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin : stimulus
    int frame_no;
    int r;
    int len;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: noise while hunting, repeated sync, sync broken by another
    // byte, oversized lengths, empty good frame, CRC mismatch
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(SYNC_FIRST, 1'b1);
    send_frame(8'hFF, MAX_PAYLOAD + 1, 1'b0, KEEP_ALL);
    send_byte(SYNC_FIRST, 1'b1);
    send_byte(8'h00, 1'b1);
    send_frame(8'h5A, 255, 1'b0, KEEP_ALL);
    send_frame(8'h00, 0, 1'b0, KEEP_ALL);
    send_frame(8'h81, 1, 1'b1, KEEP_ALL);
    wait_drained();

    // random: mostly well-formed frames, some rejects, noise and cut frames
    items_sent = 0;
    frame_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
      if (frame_no == 0) begin
        send_frame(8'hFF, MAX_PAYLOAD, 1'b0, KEEP_ALL);
      end else if (frame_no == 8) begin
        // sink holds off while the sender keeps offering
        wait_drained();
        hold_req = 1'b1;
        send_frame(8'($urandom), 4, 1'b0, KEEP_ALL);
        send_frame(8'($urandom), 2, 1'b0, KEEP_ALL);
        send_frame(8'($urandom), 0, 1'b0, KEEP_ALL);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          r = $urandom_range(0, 99);
          if (r < 85) len = $urandom_range(0, 8);
          else if (r < 97) len = $urandom_range(9, 32);
          else len = $urandom_range(33, MAX_PAYLOAD);
          send_frame(8'($urandom), len, ($urandom_range(0, 9) == 0), KEEP_ALL);
        end else if (r < 80) begin
          send_frame(8'($urandom), $urandom_range(MAX_PAYLOAD + 1, 255), 1'b0, KEEP_ALL);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end else begin
          len = $urandom_range(1, 16);
          send_frame(8'($urandom), len, 1'b0, $urandom_range(3, len + 5));
        end
      end
      frame_no++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("ERROR: %0d predicted results never arrived", sb.pending.size());
    end

    $display("Run covered %0d link bytes and %0d checked results in %0d cycles.",
             sb.bytes_seen, sb.checked, cycle_count);
    $display("Frames: %0d good, %0d oversized length, %0d bad CRC; %0d mismatches.",
             sb.n_good, sb.n_len, sb.n_crc, sb.mismatches);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
